[hdl/avpq_pkg.sv]
`timescale 1ns / 1ps

package avpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int VAL_W    = 32;
  // ordering key: magnitude above, positive flag in the lsb
  localparam int KEY_W    = VAL_W + 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic signed [VAL_W-1:0] value;
  } avpq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic                    was_empty;
    logic                    was_full;
  } avpq_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [KEY_W-1:0] key;
  } avpq_cell_cmd_t;

  // smaller key comes first; zero counts as negative
  function automatic logic [KEY_W-1:0] value_to_key(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] mag;
    logic             neg;
    mag = v[VAL_W-1] ? (~v + {{(VAL_W-1){1'b0}}, 1'b1}) : v;
    neg = v[VAL_W-1] || (v == '0);
    return {mag, ~neg};
  endfunction

  function automatic logic [VAL_W-1:0] key_to_value(input logic [KEY_W-1:0] k);
    logic [VAL_W-1:0] mag;
    mag = k[KEY_W-1:1];
    return k[0] ? mag : (~mag + {{(VAL_W-1){1'b0}}, 1'b1});
  endfunction

endpackage

[hdl/avpq_cell.sv]
`timescale 1ns / 1ps

module avpq_cell (
  input  logic                         clk,
  input  avpq_pkg::avpq_cell_cmd_t     cmd,
  input  logic                         occ,
  input  logic [avpq_pkg::KEY_W-1:0]   prev_key,
  input  logic                         prev_ins,
  input  logic [avpq_pkg::KEY_W-1:0]   next_key,
  output logic [avpq_pkg::KEY_W-1:0]   key_o,
  output logic                         ins_o
);
  import avpq_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;

  // new key goes in at or before this slot
  assign ins_o = !occ || (cmd.key < key_r);
  assign key_o = key_r;

  always_comb begin
    key_nxt = key_r;
    if (cmd.push) begin
      if (prev_ins) begin
        key_nxt = prev_key;
      end else if (ins_o) begin
        key_nxt = cmd.key;
      end
    end else if (cmd.pop) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

[hdl/absolute_value_priority_queue_top.sv]
`timescale 1ns / 1ps

// channel | direction | ports                         | word
// in      | input     | in_valid, in_ready, in_data   | cmd, value
// out     | output    | out_valid, out_ready, out_data| popped_value, was_empty, was_full
//
// one word per cycle: each word is done at its accept edge, where every cell of
// the sorted row compares the broadcast key with its own and shifts or loads
// a word stalls only while an unread result sits in the output register
// reset clears the entry count and the output valid; cell contents are not
// reset, cells at or above the count are treated as empty

module absolute_value_priority_queue_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  avpq_pkg::avpq_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output avpq_pkg::avpq_out_t  out_data
);
  import avpq_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  avpq_out_t        out_data_r;
  avpq_out_t        out_data_nxt;

  logic             in_acc;
  logic             is_full;
  logic             is_empty;
  avpq_cell_cmd_t   cell_cmd;

  // the sorted row: cell 0 holds the front entry
  logic [KEY_W-1:0] key_w [CAPACITY];
  logic             ins_w [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign is_full  = (cnt_r == CNT_W'(CAPACITY));
  assign is_empty = (cnt_r == '0);

  // only legal pushes and pops reach the row
  assign cell_cmd.push = in_acc && (in_data.cmd == CMD_PUSH) && !is_full;
  assign cell_cmd.pop  = in_acc && (in_data.cmd == CMD_POP) && !is_empty;
  assign cell_cmd.key  = value_to_key(in_data.value);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic             prev_ins;
    logic [KEY_W-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_key = '0;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_key = key_w[i-1];
      assign prev_ins = ins_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = key_w[i];
    end else begin : g_inner
      assign next_key = key_w[i+1];
    end

    avpq_cell u_cell (
      .clk      (clk),
      .cmd      (cell_cmd),
      .occ      (CNT_W'(i) < cnt_r),
      .prev_key (prev_key),
      .prev_ins (prev_ins),
      .next_key (next_key),
      .key_o    (key_w[i]),
      .ins_o    (ins_w[i])
    );
  end

  // entry count and result word
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cell_cmd.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cell_cmd.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (in_acc) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.popped_value = '0;
      out_data_nxt.was_empty    = 1'b0;
      out_data_nxt.was_full     = 1'b0;
      if (in_data.cmd == CMD_POP) begin
        if (is_empty) begin
          out_data_nxt.was_empty = 1'b1;
        end else begin
          out_data_nxt.popped_value = key_to_value(key_w[0]);
        end
      end else if (is_full) begin
        out_data_nxt.was_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a pop on an empty queue reports empty and leaves the count alone
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == CMD_POP && is_empty)
      |=> (out_valid && out_data.was_empty && cnt_r == '0))
    else $error("empty pop not flagged");

  // a push into a full queue is refused and flagged
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == CMD_PUSH && is_full)
      |=> (out_valid && out_data.was_full && $stable(cnt_r)))
    else $error("full push not refused");

  // the front never moves ahead after a pop
  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_cmd.pop && cnt_r > CNT_W'(1)) |=> (key_w[0] >= $past(key_w[0])))
    else $error("front order broken by pop");

  // after a push the count stays within capacity and is not zero
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cell_cmd.push |=> (cnt_r <= CNT_W'(CAPACITY) && cnt_r != '0))
    else $error("entry count out of range");

endmodule

[test/absolute_value_priority_queue_top_tb.sv]
`timescale 1ns / 1ps

module absolute_value_priority_queue_top_tb;
  import avpq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  avpq_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  avpq_out_t out_data;

  absolute_value_priority_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // words waiting for the driver, and the results the heap mirror says are due
  avpq_in_t  words_to_send[$];
  avpq_out_t results_due[$];
  int        err_count = 0;

  // heap mirror: binary heap array layout with the same sift rules
  logic [VAL_W-1:0] mirror_heap [CAPACITY];
  int unsigned      mirror_count = 0;

  function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? ('0 - v) : v;
  endfunction

  // zero sorts with the negatives
  function automatic bit neg_or_zero(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] || (v == '0);
  endfunction

  function automatic bit goes_first(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    if (mag_of(a) != mag_of(b))
      return mag_of(a) < mag_of(b);
    return neg_or_zero(a) && !neg_or_zero(b);
  endfunction

  task automatic apply_word(input avpq_in_t w, output avpq_out_t r);
    int unsigned      pos;
    int unsigned      up;
    int unsigned      lt;
    int unsigned      rt;
    int unsigned      pick;
    logic [VAL_W-1:0] t;
    bit               done;
    r = '0;
    done = 1'b0;
    if (w.cmd == CMD_PUSH) begin
      if (mirror_count >= CAPACITY) begin
        r.was_full = 1'b1;
      end else begin
        pos = mirror_count;
        mirror_heap[pos] = w.value;
        mirror_count++;
        // sift up, stop on anything not strictly ahead of its parent
        while (pos > 0 && !done) begin
          up = (pos - 1) / 2;
          if (!goes_first(mirror_heap[pos], mirror_heap[up])) begin
            done = 1'b1;
          end else begin
            t = mirror_heap[pos];
            mirror_heap[pos] = mirror_heap[up];
            mirror_heap[up] = t;
            pos = up;
          end
        end
      end
    end else if (mirror_count == 0) begin
      r.was_empty = 1'b1;
    end else begin
      r.popped_value = mirror_heap[0];
      mirror_count--;
      mirror_heap[0] = mirror_heap[mirror_count];
      pos = 0;
      // sift down; on a full tie between children the right one wins
      while (!done) begin
        lt = 2 * pos + 1;
        rt = lt + 1;
        if (lt >= mirror_count) begin
          done = 1'b1;
        end else begin
          pick = lt;
          if (rt < mirror_count && !goes_first(mirror_heap[lt], mirror_heap[rt]))
            pick = rt;
          if (!goes_first(mirror_heap[pick], mirror_heap[pos])) begin
            done = 1'b1;
          end else begin
            t = mirror_heap[pos];
            mirror_heap[pos] = mirror_heap[pick];
            mirror_heap[pick] = t;
            pos = pick;
          end
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  function automatic avpq_in_t make_word(input logic c, input logic [VAL_W-1:0] v);
    avpq_in_t w;
    w.cmd = c;
    w.value = (c == CMD_PUSH) ? v : logic'($urandom_range(0, 1)) ? $urandom() : '0;
    return w;
  endfunction

  // mix of full-range values, small ones that tie often, and the extremes
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2: v = VAL_W'($urandom_range(0, 12)) - VAL_W'(6);
      3: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1)
          v = '0 - v;
      end
      4: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0001;
          2: v = 32'h8000_0000;
          3: v = '0;
          4: v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = VAL_W'($urandom_range(0, 40)) - VAL_W'(20);
    endcase
    return v;
  endfunction

  // driver: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    avpq_out_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_word(in_data, r);
        results_due.push_back(r);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          in_data <= words_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each word against the oldest result due; ready follows
  // one of four patterns, re-drawn at random as the tick count advances
  int unsigned rx_tick = 0;
  int unsigned rx_mode = 0;

  always @(posedge clk) begin
    avpq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result word with nothing due", out_data.popped_value, '0);
      end else begin
        want = results_due.pop_front();
        if (out_data.popped_value !== want.popped_value)
          flag_mismatch("popped_value", out_data.popped_value, want.popped_value);
        if (out_data.was_empty !== want.was_empty)
          flag_mismatch("was_empty", VAL_W'(out_data.was_empty), VAL_W'(want.was_empty));
        if (out_data.was_full !== want.was_full)
          flag_mismatch("was_full", VAL_W'(out_data.was_full), VAL_W'(want.was_full));
      end
    end
    rx_tick++;
    if (rx_tick % 256 == 0)
      rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= logic'($urandom_range(0, 1));
      2: out_ready <= (rx_tick % 5 == 0);
      default: out_ready <= (rx_tick % 16) < 12;
    endcase
  end

  // stimulus
  initial begin
    int push_pct;
    int seg;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, extremes, zero, ties of equal magnitude and sign,
    // most negative value, then drain in order and pop past empty
    words_to_send.push_back(make_word(CMD_POP, '0));
    words_to_send.push_back(make_word(CMD_PUSH, 32'h0000_0000));
    words_to_send.push_back(make_word(CMD_PUSH, 32'h7FFF_FFFF));
    words_to_send.push_back(make_word(CMD_PUSH, 32'h8000_0001));
    words_to_send.push_back(make_word(CMD_PUSH, 32'h8000_0000));
    words_to_send.push_back(make_word(CMD_PUSH, 32'd5));
    words_to_send.push_back(make_word(CMD_PUSH, -32'sd5));
    words_to_send.push_back(make_word(CMD_PUSH, 32'd5));
    words_to_send.push_back(make_word(CMD_PUSH, -32'sd5));
    words_to_send.push_back(make_word(CMD_PUSH, 32'd1));
    words_to_send.push_back(make_word(CMD_PUSH, 32'hFFFF_FFFF));
    words_to_send.push_back(make_word(CMD_PUSH, 32'h0000_0000));
    repeat (12) words_to_send.push_back(make_word(CMD_POP, '0));

    // random mix in segments, each with its own push/pop balance so the
    // heap both grows deep and runs dry; halfway through, hold off until
    // every result is back before queuing the rest
    for (seg = 0; seg < 18; seg++) begin
      case ($urandom_range(0, 3))
        0: push_pct = 30;
        1: push_pct = 50;
        2: push_pct = 70;
        default: push_pct = 90;
      endcase
      repeat (50) begin
        if ($urandom_range(0, 99) < push_pct)
          words_to_send.push_back(make_word(CMD_PUSH, pick_value()));
        else
          words_to_send.push_back(make_word(CMD_POP, '0));
      end
      if (seg == 8) begin
        while (words_to_send.size() > 0 || in_valid || results_due.size() > 0)
          @(posedge clk);
      end
    end

    while (words_to_send.size() > 0 || in_valid || results_due.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("absolute_value_priority_queue_top_tb: done, clean");
    else
      $display("absolute_value_priority_queue_top_tb: done, errors");
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("absolute_value_priority_queue_top_tb: done, errors");
    $finish;
  end

endmodule
